/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside of reset
`define BSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define BSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/bsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Types, constants and decode functions of the branch scan predecoder.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int BSP_FIFO_DEPTH = 4;
    localparam int BSP_FIFO_AW    = $clog2(BSP_FIFO_DEPTH);
    localparam int BSP_FIFO_CW    = $clog2(BSP_FIFO_DEPTH + 1);
    localparam int BSP_CFG_IW     = 1;

    localparam logic [BSP_CFG_IW-1:0] CFG_REPORT_CALLS    = 1'b0;
    localparam logic [BSP_CFG_IW-1:0] CFG_REPORT_BRANCHES = 1'b1;

    localparam logic [7:0] OP_BRANCH_13 = 8'h13;
    localparam logic [7:0] OP_CALL_44   = 8'h44;
    localparam logic [7:0] OP_CALL_45   = 8'h45;
    localparam logic [7:0] OP_BRANCH_48 = 8'h48;
    localparam logic [7:0] OP_BRANCH_49 = 8'h49;
    localparam logic [7:0] OP_BRANCH_4C = 8'h4c;
    localparam logic [7:0] OP_BRANCH_4D = 8'h4d;

    localparam logic [3:0] AM_PCREL32 = 4'd1;
    localparam logic [3:0] AM_ABS32   = 4'd3;
    localparam logic [3:0] AM_DISP48  = 4'd6;
    localparam logic [3:0] AM_PCREL16 = 4'd9;
    localparam logic [3:0] AM_DISP10  = 4'd10;
    localparam logic [3:0] AM_ABS16   = 4'd11;
    localparam logic [3:0] AM_DISP13  = 4'd13;
    localparam logic [3:0] AM_DISP14  = 4'd14;

    typedef enum logic [1:0] {
        CLS_PLAIN,
        CLS_IMM,
        CLS_MACRO,
        CLS_ADDR
    } t_op_class;

    typedef enum logic [1:0] {
        JK_NONE   = 2'd0,
        JK_CALL   = 2'd1,
        JK_BRANCH = 2'd2
    } t_jump_kind;

    typedef enum logic [1:0] {
        REC_CALL   = 2'd0,
        REC_BRANCH = 2'd1,
        REC_END    = 2'd2
    } t_record_kind;

    typedef struct packed {
        logic [15:0] parcel;
        logic [31:0] parcel_address;
        logic        final_parcel;
    } t_parcel;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] site_address;
        logic [31:0] target_address;
    } t_record;

    typedef struct packed {
        logic [1:0] n;
        t_record    a;
        t_record    b;
    } t_push;

    typedef struct packed {
        logic                   room2;
        logic [BSP_FIFO_CW-1:0] level;
    } t_fifo_stat;

    function automatic t_op_class op_class(input logic [7:0] op);
        t_op_class cls;
        priority if (op >= 8'h38 && op <= 8'h3d) begin
            cls = CLS_IMM;
        end else if (op == 8'h83 || op == 8'h87 || op == 8'h8b || op == 8'h8f) begin
            cls = CLS_IMM;
        end else if (op == 8'ha3 || op == 8'ha7 || op == 8'hab) begin
            cls = CLS_IMM;
        end else if (op == 8'hb4 || op == 8'hb6) begin
            cls = CLS_MACRO;
        end else if (op == OP_CALL_44 || op == OP_CALL_45 || op == OP_BRANCH_48 ||
                     op == OP_BRANCH_49 || op == OP_BRANCH_4C || op == OP_BRANCH_4D) begin
            cls = CLS_ADDR;
        end else if (op >= 8'h60 && op <= 8'h7f && op != 8'h73) begin
            cls = CLS_ADDR;
        end else begin
            cls = CLS_PLAIN;
        end
        return cls;
    endfunction

    function automatic t_jump_kind jump_kind(input logic [7:0] op);
        t_jump_kind k;
        priority if (op == OP_CALL_44 || op == OP_CALL_45) begin
            k = JK_CALL;
        end else if (op == OP_BRANCH_13 || op == OP_BRANCH_48 || op == OP_BRANCH_49 ||
                     op == OP_BRANCH_4C || op == OP_BRANCH_4D) begin
            k = JK_BRANCH;
        end else begin
            k = JK_NONE;
        end
        return k;
    endfunction

    function automatic logic [1:0] extra_words(input logic [15:0] parcel);
        logic [3:0] mode;
        logic [1:0] n;
        mode = parcel[7:4];
        n    = 2'd0;
        unique case (op_class(parcel[15:8]))
            CLS_IMM:   n = (mode == AM_ABS16) ? 2'd1 : 2'd2;
            CLS_MACRO: n = 2'd1;
            CLS_ADDR: begin
                if (parcel[8]) begin
                    unique case (mode)
                        AM_PCREL32, AM_ABS32: n = 2'd2;
                        AM_DISP48:            n = 2'd3;
                        AM_PCREL16, AM_DISP10, AM_ABS16, AM_DISP13, AM_DISP14: n = 2'd1;
                        default:              n = 2'd0;
                    endcase
                end
            end
            CLS_PLAIN: n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] decode_target(input logic [31:0] site,
                                                  input logic [3:0]  mode,
                                                  input logic [15:0] low,
                                                  input logic [15:0] last);
        logic [31:0] t;
        unique case (mode)
            AM_PCREL32: t = site + {last, low};
            AM_ABS32:   t = {last, low};
            AM_PCREL16: t = site + {{16{last[15]}}, last};
            AM_ABS16:   t = {{16{last[15]}}, last};
            default:    t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/bsp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_in_if
// Parcel input channel: valid/ready with one instruction parcel.
// ----------------------------------------------------------------------------
interface bsp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] parcel;
    logic [31:0] parcel_address;
    logic        final_parcel;

    modport source (output valid, output parcel, output parcel_address,
                    output final_parcel, input ready);
    modport sink   (input valid, input parcel, input parcel_address,
                    input final_parcel, output ready);
endinterface

/* rtl/bsp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_out_if
// Record output channel: valid/ready with one call, branch or end record.
// ----------------------------------------------------------------------------
interface bsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [31:0] site_address;
    logic [31:0] target_address;

    modport source (output valid, output record_kind, output site_address,
                    output target_address, input ready);
    modport sink   (input valid, input record_kind, input site_address,
                    input target_address, output ready);
endinterface

/* rtl/bsp_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface bsp_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bsp_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_decode
// Input register, scan state and single-pass parcel decode into records.
// ----------------------------------------------------------------------------
module bsp_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  bsp_pkg::t_parcel i_item,
    input  logic             i_room2,
    input  logic             i_report_calls,
    input  logic             i_report_branches,
    output logic             o_in_ready,
    output logic             o_advance,
    output bsp_pkg::t_push   o_push
);
    import bsp_pkg::*;

    logic        r_valid;
    t_parcel     r_item;
    logic [1:0]  r_wp, n_wp;
    logic [1:0]  r_es, n_es;
    logic [31:0] r_site, n_site;
    t_jump_kind  r_kind, n_kind;
    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_low, n_low;

    logic        rep_valid;
    t_jump_kind  rep_kind;
    logic [31:0] rep_site;
    logic [31:0] rep_target;
    logic        clear;
    logic        want;
    t_record     rec_rep;
    t_record     rec_end;
    t_jump_kind  op_kind;
    logic [1:0]  op_extra;

    assign o_advance  = r_valid && i_room2;
    assign o_in_ready = !r_valid || o_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (o_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 2'd0;
            r_es   <= 2'd0;
            r_site <= 32'd0;
            r_kind <= JK_NONE;
            r_mode <= 4'd0;
            r_low  <= 16'd0;
        end else if (o_advance) begin
            r_wp   <= n_wp;
            r_es   <= n_es;
            r_site <= n_site;
            r_kind <= n_kind;
            r_mode <= n_mode;
            r_low  <= n_low;
        end
    end

    always_comb begin
        n_wp       = r_wp;
        n_es       = r_es;
        n_site     = r_site;
        n_kind     = r_kind;
        n_mode     = r_mode;
        n_low      = r_low;
        rep_valid  = 1'b0;
        rep_kind   = JK_NONE;
        rep_site   = 32'd0;
        rep_target = 32'd0;
        clear      = r_item.final_parcel;
        op_kind    = jump_kind(r_item.parcel[15:8]);
        op_extra   = extra_words(r_item.parcel);

        if (r_wp == 2'd0) begin
            if (op_extra == 2'd0) begin
                rep_valid = (op_kind != JK_NONE);
                rep_kind  = op_kind;
                rep_site  = r_item.parcel_address;
            end else begin
                n_wp   = op_extra;
                n_es   = 2'd0;
                n_site = r_item.parcel_address;
                n_kind = op_kind;
                n_mode = r_item.parcel[7:4];
                n_low  = 16'd0;
            end
        end else if (r_wp == 2'd1) begin
            rep_valid  = (r_kind != JK_NONE);
            rep_kind   = r_kind;
            rep_site   = r_site;
            rep_target = decode_target(r_site, r_mode, r_low, r_item.parcel);
            clear      = 1'b1;
        end else begin
            if (r_es == 2'd0) begin
                n_low = r_item.parcel;
            end
            n_es = r_es + 2'd1;
            n_wp = r_wp - 2'd1;
        end

        // drop any partial instruction
        if (clear) begin
            n_wp   = 2'd0;
            n_es   = 2'd0;
            n_site = 32'd0;
            n_kind = JK_NONE;
            n_mode = 4'd0;
            n_low  = 16'd0;
        end
    end

    always_comb begin
        want = rep_valid && ((rep_kind == JK_CALL && i_report_calls) ||
                             (rep_kind == JK_BRANCH && i_report_branches));
        rec_rep.record_kind    = (rep_kind == JK_CALL) ? REC_CALL : REC_BRANCH;
        rec_rep.site_address   = rep_site;
        rec_rep.target_address = rep_target;
        rec_end.record_kind    = REC_END;
        rec_end.site_address   = 32'd0;
        rec_end.target_address = 32'd0;

        o_push.b = rec_end;
        if (want) begin
            o_push.a = rec_rep;
            o_push.n = r_item.final_parcel ? 2'd2 : 2'd1;
        end else begin
            o_push.a = rec_end;
            o_push.n = r_item.final_parcel ? 2'd1 : 2'd0;
        end
        if (!o_advance) begin
            o_push.n = 2'd0;
        end
    end

endmodule

/* rtl/bsp_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_result_fifo
// Small record queue taking up to two records per cycle, one out per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module bsp_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsp_pkg::t_push       i_push,
    input  logic                 i_pop_ready,
    output logic                 o_valid,
    output bsp_pkg::t_record     o_record,
    output bsp_pkg::t_fifo_stat  o_stat
);
    import bsp_pkg::*;

    t_record                r_mem [BSP_FIFO_DEPTH];
    logic [BSP_FIFO_AW-1:0] r_wr, n_wr;
    logic [BSP_FIFO_AW-1:0] r_rd, n_rd;
    logic [BSP_FIFO_CW-1:0] r_level, n_level;
    logic                   pop;
    logic [BSP_FIFO_AW-1:0] wr_next;

    assign o_valid  = (r_level != '0);
    assign o_record = r_mem[r_rd];
    assign pop      = o_valid && i_pop_ready;
    assign wr_next  = r_wr + BSP_FIFO_AW'(1);

    assign o_stat.level = r_level;
    assign o_stat.room2 = (r_level <= BSP_FIFO_CW'(BSP_FIFO_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + BSP_FIFO_AW'(i_push.n);
        n_rd    = pop ? r_rd + BSP_FIFO_AW'(1) : r_rd;
        n_level = r_level + BSP_FIFO_CW'(i_push.n) - BSP_FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_next] <= i_push.b;
        end
    end

endmodule

/* rtl/branch_scan_predecoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_scan_predecoder_unit
// Scans 16-bit instruction parcels and reports calls, branches and region ends.
// ----------------------------------------------------------------------------
// Channels: i_in takes one parcel with its byte address and a final flag per
// transfer; o_out gives records (call, branch, end marker) with site and
// target address; i_cfg writes the two report enables (index 0 calls,
// index 1 branches) and is always ready.
// Path: a record reaches o_out from the parcel transfer that completes its
// instruction through the input register, then the decode pass into the
// result queue.
// Throughput: one parcel per cycle while two queue entries are free; the limit
// is the single record read per cycle from the four-entry result queue, so a
// final parcel that also closes a reported jump leaves two records to read.
// Reset: the scan state clears, no instruction is in flight, both enables
// are set and the result queue is empty.
// Stall: while o_out is held, records wait in the queue; parcels keep being
// taken until fewer than two queue entries remain free, then i_in.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module branch_scan_predecoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsp_in_if.sink     i_in,
    bsp_out_if.source  o_out,
    bsp_cfg_if.sink    i_cfg
);
    import bsp_pkg::*;

    logic       r_report_calls;
    logic       r_report_branches;
    logic       w_take;
    logic       w_advance;
    t_parcel    w_item;
    t_push      w_push;
    t_record    w_record;
    t_fifo_stat w_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_calls    <= 1'b1;
            r_report_branches <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_REPORT_CALLS:    r_report_calls    <= i_cfg.data;
                CFG_REPORT_BRANCHES: r_report_branches <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_item.parcel         = i_in.parcel;
    assign w_item.parcel_address = i_in.parcel_address;
    assign w_item.final_parcel   = i_in.final_parcel;
    assign w_take                = i_in.valid && i_in.ready;

    bsp_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_take            (w_take),
        .i_item            (w_item),
        .i_room2           (w_stat.room2),
        .i_report_calls    (r_report_calls),
        .i_report_branches (r_report_branches),
        .o_in_ready        (i_in.ready),
        .o_advance         (w_advance),
        .o_push            (w_push)
    );

    bsp_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_record    (w_record),
        .o_stat      (w_stat)
    );

    assign o_out.record_kind    = w_record.record_kind;
    assign o_out.site_address   = w_record.site_address;
    assign o_out.target_address = w_record.target_address;

    `BSP_ASSERT(a_level_bound, i_clk, i_rst_n, w_stat.level <= BSP_FIFO_CW'(BSP_FIFO_DEPTH), "result queue overfilled")
    `BSP_ASSERT(a_pair_ends, i_clk, i_rst_n, (w_push.n == 2'd2) |-> (w_push.b.record_kind == REC_END), "second record of a pair is not an end marker")
    `BSP_ASSERT(a_push_on_advance, i_clk, i_rst_n, (w_push.n != 2'd0) |-> w_advance, "record pushed without a decoded parcel")
    `BSP_ASSERT(a_push_room, i_clk, i_rst_n, (w_push.n != 2'd0) |-> w_stat.room2, "record pushed with the queue nearly full")

endmodule

/* test/branch_record_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_record_check
// Watches the parcel, record and configuration channels of the predecoder,
// runs its own model of the instruction scan on every accepted parcel and
// compares each record that leaves the block against the oldest one owed.
// ----------------------------------------------------------------------------
module branch_record_check (
    input  logic i_clk,
    input  logic i_rst_n,
    bsp_in_if    i_parcels,
    bsp_out_if   i_records,
    bsp_cfg_if   i_cfg,
    output int   o_mismatch_count,
    output int   o_records_owed
);
    import bsp_pkg::*;

    localparam logic [7:0] OP_IMM_FIRST   = 8'h38;
    localparam logic [7:0] OP_IMM_LAST    = 8'h3d;
    localparam logic [7:0] OP_IMM_83      = 8'h83;
    localparam logic [7:0] OP_IMM_87      = 8'h87;
    localparam logic [7:0] OP_IMM_8B      = 8'h8b;
    localparam logic [7:0] OP_IMM_8F      = 8'h8f;
    localparam logic [7:0] OP_IMM_A3      = 8'ha3;
    localparam logic [7:0] OP_IMM_A7      = 8'ha7;
    localparam logic [7:0] OP_IMM_AB      = 8'hab;
    localparam logic [7:0] OP_MACRO_B4    = 8'hb4;
    localparam logic [7:0] OP_MACRO_B6    = 8'hb6;
    localparam logic [7:0] OP_ADDR_FIRST  = 8'h60;
    localparam logic [7:0] OP_ADDR_LAST   = 8'h7f;
    localparam logic [7:0] OP_PLAIN_73    = 8'h73;

    t_record     owed_records[$];
    t_record     due;
    logic        en_calls;
    logic        en_branches;
    logic [1:0]  words_left;
    logic [1:0]  ext_done;
    logic [31:0] site_q;
    t_jump_kind  kind_q;
    logic [3:0]  mode_q;
    logic [15:0] low_q;

    function automatic t_op_class parcel_class(input logic [7:0] op);
        if ((op >= OP_IMM_FIRST && op <= OP_IMM_LAST) || op == OP_IMM_83 ||
            op == OP_IMM_87 || op == OP_IMM_8B || op == OP_IMM_8F ||
            op == OP_IMM_A3 || op == OP_IMM_A7 || op == OP_IMM_AB) begin
            return CLS_IMM;
        end
        if (op == OP_MACRO_B4 || op == OP_MACRO_B6) begin
            return CLS_MACRO;
        end
        if (op == OP_CALL_44 || op == OP_CALL_45 || op == OP_BRANCH_48 ||
            op == OP_BRANCH_49 || op == OP_BRANCH_4C || op == OP_BRANCH_4D ||
            (op >= OP_ADDR_FIRST && op <= OP_ADDR_LAST && op != OP_PLAIN_73)) begin
            return CLS_ADDR;
        end
        return CLS_PLAIN;
    endfunction

    function automatic t_jump_kind opcode_kind(input logic [7:0] op);
        if (op == OP_CALL_44 || op == OP_CALL_45) begin
            return JK_CALL;
        end
        if (op == OP_BRANCH_13 || op == OP_BRANCH_48 || op == OP_BRANCH_49 ||
            op == OP_BRANCH_4C || op == OP_BRANCH_4D) begin
            return JK_BRANCH;
        end
        return JK_NONE;
    endfunction

    // extension parcels following an instruction head
    function automatic logic [1:0] tail_len(input logic [15:0] head);
        logic [3:0] mode;
        logic [1:0] n;
        mode = head[7:4];
        n    = 2'd0;
        case (parcel_class(head[15:8]))
            CLS_IMM: begin
                n = (mode == AM_ABS16) ? 2'd1 : 2'd2;
            end
            CLS_MACRO: begin
                n = 2'd1;
            end
            CLS_ADDR: begin
                if (head[8]) begin
                    case (mode)
                        AM_PCREL32, AM_ABS32: n = 2'd2;
                        AM_DISP48:            n = 2'd3;
                        AM_PCREL16, AM_DISP10, AM_ABS16, AM_DISP13, AM_DISP14: n = 2'd1;
                        default:              n = 2'd0;
                    endcase
                end
            end
            default: begin
                n = 2'd0;
            end
        endcase
        return n;
    endfunction

    function automatic logic [31:0] jump_dest(input logic [31:0] site,
                                              input logic [3:0]  mode,
                                              input logic [15:0] lo_word,
                                              input logic [15:0] hi_word);
        case (mode)
            AM_PCREL32: return site + {hi_word, lo_word};
            AM_ABS32:   return {hi_word, lo_word};
            AM_PCREL16: return site + {{16{hi_word[15]}}, hi_word};
            AM_ABS16:   return {{16{hi_word[15]}}, hi_word};
            default:    return 32'd0;
        endcase
    endfunction

    task automatic report(input string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        o_mismatch_count++;
    endtask

    task automatic clear_scan();
        words_left = 2'd0;
        ext_done   = 2'd0;
        site_q     = 32'd0;
        kind_q     = JK_NONE;
        mode_q     = 4'd0;
        low_q      = 16'd0;
    endtask

    task automatic owe_jump(input t_jump_kind k, input logic [31:0] site,
                            input logic [31:0] target);
        t_record r;
        r.site_address   = site;
        r.target_address = target;
        if (k == JK_CALL && en_calls) begin
            r.record_kind = REC_CALL;
            owed_records.push_back(r);
        end else if (k == JK_BRANCH && en_branches) begin
            r.record_kind = REC_BRANCH;
            owed_records.push_back(r);
        end
    endtask

    task automatic take_parcel(input logic [15:0] p, input logic [31:0] addr,
                               input logic fin);
        logic [1:0] n;
        t_jump_kind k;
        t_record    marker;
        if (words_left == 2'd0) begin
            k = opcode_kind(p[15:8]);
            n = tail_len(p);
            if (n == 2'd0) begin
                if (k != JK_NONE) begin
                    owe_jump(k, addr, 32'd0);
                end
            end else begin
                words_left = n;
                ext_done   = 2'd0;
                site_q     = addr;
                kind_q     = k;
                mode_q     = p[7:4];
                low_q      = 16'd0;
            end
        end else if (words_left == 2'd1) begin
            if (kind_q != JK_NONE) begin
                owe_jump(kind_q, site_q, jump_dest(site_q, mode_q, low_q, p));
            end
            clear_scan();
        end else begin
            if (ext_done == 2'd0) begin
                low_q = p;
            end
            ext_done   = ext_done + 2'd1;
            words_left = words_left - 2'd1;
        end
        // end of region drops any unfinished instruction
        if (fin) begin
            marker.record_kind    = REC_END;
            marker.site_address   = 32'd0;
            marker.target_address = 32'd0;
            owed_records.push_back(marker);
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            en_calls    = 1'b1;
            en_branches = 1'b1;
            clear_scan();
            owed_records.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_REPORT_CALLS) begin
                    en_calls = i_cfg.data;
                end else begin
                    en_branches = i_cfg.data;
                end
            end
            if (i_parcels.valid && i_parcels.ready) begin
                take_parcel(i_parcels.parcel, i_parcels.parcel_address,
                            i_parcels.final_parcel);
            end
            if (i_records.valid && i_records.ready) begin
                if (owed_records.size() == 0) begin
                    report($sformatf("record with none owed: kind %0d site %h target %h",
                                     i_records.record_kind, i_records.site_address,
                                     i_records.target_address));
                end else begin
                    due = owed_records.pop_front();
                    if (i_records.record_kind !== due.record_kind) begin
                        report($sformatf("record kind %0d, expected %0d (site %h)",
                                         i_records.record_kind, due.record_kind,
                                         due.site_address));
                    end
                    if (i_records.site_address !== due.site_address) begin
                        report($sformatf("site address %h, expected %h",
                                         i_records.site_address, due.site_address));
                    end
                    if (i_records.target_address !== due.target_address) begin
                        report($sformatf("target address %h, expected %h (site %h)",
                                         i_records.target_address, due.target_address,
                                         due.site_address));
                    end
                end
            end
        end
        o_records_owed = owed_records.size();
    end

endmodule

/* test/branch_scan_predecoder_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_scan_predecoder_unit_test
// Drives parcel streams into the predecoder: a directed set of corner cases,
// then phases of random instruction sequences under different report enables,
// with random gaps and stalls, a long output hold-off and a drained pause.
// ----------------------------------------------------------------------------
module branch_scan_predecoder_unit_test;
    import bsp_pkg::*;

    localparam logic [7:0] OP_PLAIN_00   = 8'h00;
    localparam logic [7:0] OP_PLAIN_FF   = 8'hff;
    localparam logic [7:0] OP_PLAIN_73   = 8'h73;
    localparam logic [7:0] OP_IMM_FIRST  = 8'h38;
    localparam logic [7:0] OP_IMM_LAST   = 8'h3d;
    localparam logic [7:0] OP_MACRO_B4   = 8'hb4;
    localparam logic [7:0] OP_MACRO_B6   = 8'hb6;
    localparam logic [7:0] OP_ADDR_FIRST = 8'h60;
    localparam logic [7:0] OP_ADDR_61    = 8'h61;
    localparam logic [7:0] OP_ADDR_LAST  = 8'h7f;
    localparam logic [3:0] AM_PLAIN_2    = 4'd2;

    localparam logic [7:0] JUMP_OPS [7] = '{OP_BRANCH_13, OP_CALL_44, OP_CALL_45,
                                           OP_BRANCH_48, OP_BRANCH_49,
                                           OP_BRANCH_4C, OP_BRANCH_4D};
    localparam logic [3:0] MODE_POOL [8] = '{AM_PCREL32, AM_ABS32, AM_DISP48,
                                            AM_PCREL16, AM_DISP10, AM_ABS16,
                                            AM_DISP13, AM_DISP14};

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    int          mismatch_count;
    int          records_owed;
    logic [31:0] pc;
    bit          sender_idles;
    bit          receiver_idles;
    int          hold_off_cycles;
    int          parcels_sent;

    bsp_in_if  parcel_bus ();
    bsp_out_if record_bus ();
    bsp_cfg_if cfg_bus ();

    branch_scan_predecoder_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (parcel_bus),
        .o_out   (record_bus),
        .i_cfg   (cfg_bus)
    );

    branch_record_check u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_parcels        (parcel_bus),
        .i_records        (record_bus),
        .i_cfg            (cfg_bus),
        .o_mismatch_count (mismatch_count),
        .o_records_owed   (records_owed)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial begin
        #10_000_000;
        $display("FAIL branch_scan_predecoder_unit");
        $finish;
    end

    // extension length of an address-class head, as the stimulus shapes it
    function automatic int addr_tail(input logic [7:0] op, input logic [3:0] mode);
        if (!op[0]) begin
            return 0;
        end
        case (mode)
            AM_PCREL32, AM_ABS32: return 2;
            AM_DISP48:            return 3;
            AM_PCREL16, AM_DISP10, AM_ABS16, AM_DISP13, AM_DISP14: return 1;
            default:              return 0;
        endcase
    endfunction

    task automatic send_parcel(input logic [15:0] p, input logic [31:0] addr,
                               input logic fin);
        int gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            @(negedge clk) parcel_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        parcel_bus.valid          <= 1'b1;
        parcel_bus.parcel         <= p;
        parcel_bus.parcel_address <= addr;
        parcel_bus.final_parcel   <= fin;
        do @(posedge clk); while (!parcel_bus.ready);
        parcels_sent++;
    endtask

    task automatic quiesce_input();
        @(negedge clk) parcel_bus.valid <= 1'b0;
    endtask

    task automatic write_cfg(input logic [BSP_CFG_IW-1:0] idx, input logic value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk) cfg_bus.valid <= 1'b0;
    endtask

    // head parcel plus its extension parcels, sometimes cut short
    task automatic send_instruction();
        logic [7:0]  op;
        logic [3:0]  mode;
        logic [31:0] ext_addr;
        int          tail;
        int          i;
        mode = ($urandom_range(0, 2) != 0) ? MODE_POOL[$urandom_range(0, 7)]
                                           : 4'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                op   = JUMP_OPS[$urandom_range(0, 6)];
                tail = (op == OP_BRANCH_13) ? 0 : addr_tail(op, mode);
            end
            6: begin
                op   = 8'($urandom_range(OP_IMM_FIRST, OP_IMM_LAST));
                tail = (mode == AM_ABS16) ? 1 : 2;
            end
            7: begin
                op   = $urandom_range(0, 1) ? OP_MACRO_B4 : OP_MACRO_B6;
                tail = 1;
            end
            8: begin
                op   = 8'($urandom_range(OP_ADDR_FIRST, OP_ADDR_LAST));
                tail = (op == OP_PLAIN_73) ? 0 : addr_tail(op, mode);
            end
            default: begin
                op   = 8'($urandom);
                tail = 0;
            end
        endcase
        if (tail != 0 && $urandom_range(0, 9) == 0) begin
            tail = $urandom_range(0, tail - 1);
        end
        if ($urandom_range(0, 15) == 0) begin
            pc = $urandom;
        end
        send_parcel({op, mode, 4'($urandom)}, pc, $urandom_range(0, 39) == 0);
        pc += 32'd2;
        for (i = 0; i < tail; i++) begin
            ext_addr = ($urandom_range(0, 3) == 0) ? $urandom : pc;
            send_parcel(16'($urandom), ext_addr, $urandom_range(0, 39) == 0);
            pc += 32'd2;
        end
    endtask

    // wait for every owed record, then for parcels that make none
    task automatic settle();
        quiesce_input();
        wait (records_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // output side
    initial begin : receiver
        int stall;
        record_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 8) : 0;
            if (hold_off_cycles != 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall != 0) begin
                @(negedge clk) record_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) record_bus.ready <= 1'b1;
            do @(posedge clk); while (!record_bus.valid);
        end
    end

    initial begin : stimulus
        int   phase;
        int   goal;
        logic calls_on;
        logic branches_on;

        rst_n                     = 1'b0;
        parcel_bus.valid          = 1'b0;
        parcel_bus.parcel         = 16'd0;
        parcel_bus.parcel_address = 32'd0;
        parcel_bus.final_parcel   = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = CFG_REPORT_CALLS;
        cfg_bus.data              = 1'b0;
        pc                        = 32'h0000_4000;
        sender_idles              = 1'b1;
        receiver_idles            = 1'b1;
        hold_off_cycles           = 0;
        parcels_sent              = 0;

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases at the reset enables
        send_parcel({OP_PLAIN_00, 8'h00}, 32'h0000_0000, 1'b0);
        send_parcel({OP_PLAIN_FF, 8'hff}, 32'hffff_ffff, 1'b0);
        send_parcel({OP_CALL_44, 8'h00}, 32'h0000_1000, 1'b0);
        send_parcel({OP_BRANCH_13, 8'hf0}, 32'h8000_0000, 1'b0);
        // pc-relative 32-bit target wrapping past zero
        send_parcel({OP_CALL_45, AM_PCREL32, 4'h0}, 32'hffff_fff0, 1'b0);
        send_parcel(16'h0020, 32'h1234_5678, 1'b0);
        send_parcel(16'h0000, 32'hdead_beef, 1'b0);
        send_parcel({OP_BRANCH_49, AM_ABS32, 4'h5}, 32'h0000_2000, 1'b0);
        send_parcel(16'hbeef, 32'h0000_2002, 1'b0);
        send_parcel(16'hdead, 32'h0000_2004, 1'b0);
        // negative 16-bit displacement
        send_parcel({OP_BRANCH_4D, AM_PCREL16, 4'h0}, 32'h0000_0010, 1'b0);
        send_parcel(16'h8000, 32'h0000_0012, 1'b0);
        // jump closed by the final parcel gives two records
        send_parcel({OP_CALL_45, AM_ABS16, 4'hf}, 32'h7fff_fffe, 1'b0);
        send_parcel(16'hffff, 32'h8000_0000, 1'b1);
        send_parcel({OP_BRANCH_49, AM_DISP48, 4'h0}, 32'h0000_3000, 1'b0);
        send_parcel(16'h1111, 32'h0000_3002, 1'b0);
        send_parcel(16'h2222, 32'h0000_3004, 1'b0);
        send_parcel(16'h3333, 32'h0000_3006, 1'b0);
        send_parcel({OP_CALL_45, AM_PLAIN_2, 4'h0}, 32'h0000_3008, 1'b0);
        send_parcel({OP_IMM_FIRST, AM_ABS16, 4'h0}, 32'h0000_300a, 1'b0);
        send_parcel(16'h4513, 32'h0000_300c, 1'b0);
        send_parcel({OP_ADDR_61, AM_PCREL32, 4'h0}, 32'h0000_300e, 1'b0);
        send_parcel(16'h4400, 32'h0000_3010, 1'b0);
        send_parcel(16'h1300, 32'h0000_3012, 1'b0);
        // unfinished instruction dropped at the end of the region
        send_parcel({OP_CALL_45, AM_PCREL32, 4'h0}, 32'h0000_3014, 1'b0);
        send_parcel(16'h0004, 32'h0000_3016, 1'b1);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: begin calls_on = 1'b1; branches_on = 1'b1; end
                1: begin calls_on = 1'b0; branches_on = 1'b1; end
                2: begin calls_on = 1'b1; branches_on = 1'b0; end
                3: begin calls_on = 1'b0; branches_on = 1'b0; end
                4: begin calls_on = 1'b1; branches_on = 1'b1; end
                default: begin
                    calls_on    = 1'($urandom);
                    branches_on = 1'($urandom);
                end
            endcase
            write_cfg(CFG_REPORT_CALLS, calls_on);
            write_cfg(CFG_REPORT_BRANCHES, branches_on);
            sender_idles   = (phase != 1 && phase != 4);
            receiver_idles = (phase != 3 && phase != 4);
            if (phase == 1) begin
                hold_off_cycles = HOLD_CYCLES;
            end
            goal = parcels_sent + PHASE_ITEMS / 2;
            while (parcels_sent < goal) begin
                send_instruction();
            end
            if (phase == 2) begin
                quiesce_input();
                wait (records_owed == 0);
            end
            goal = parcels_sent + PHASE_ITEMS / 2;
            while (parcels_sent < goal) begin
                send_instruction();
            end
        end

        quiesce_input();
        wait (records_owed == 0);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("PASS branch_scan_predecoder_unit");
        end else begin
            $display("FAIL branch_scan_predecoder_unit");
        end
        $finish;
    end

endmodule
